// ===== hdl/tspc_pkg.sv =====
// Shared constants and types for the target sum pair counter.
package tspc_pkg;

   localparam int unsigned MAX_ELEMENTS = 256;
   localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);

   localparam int unsigned ELEM_W       = 32;
   localparam int unsigned PAIR_W       = 15;
   localparam logic [PAIR_W-1:0] PAIR_LIMIT = {PAIR_W{1'b1}};

   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // one classified word on its way from the front end to the scan engine
   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              last;
      logic              drop;
      logic [IDX_W-1:0]  slot;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0]  arr_count;
      logic [QCNT_W-1:0] q_level;
   } front_stat_type;

endpackage

// ===== hdl/tspc_ifs.sv =====
// Channel interfaces: element request, pair count response, target register write.
interface tspc_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [tspc_pkg::ELEM_W-1:0] element_value;
   logic                               last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface tspc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tspc_pkg::PAIR_W-1:0] pair_count;
   logic                        capacity_overflow;

   modport source (output valid, output pair_count, output capacity_overflow, input ready);
   modport sink   (input valid, input pair_count, input capacity_overflow, output ready);
endinterface

interface tspc_csr_if;
   logic                               valid;
   logic                               ready;
   logic signed [tspc_pkg::ELEM_W-1:0] target_sum;

   modport source (output valid, output target_sum, input ready);
   modport sink   (input valid, input target_sum, output ready);
endinterface

// ===== hdl/tspc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module tspc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/tspc_front.sv =====
// Front end: accept words, tag each with its store slot or a drop mark, and queue them.
module tspc_front (
   input  logic                     clock,
   input  logic                     reset,
   tspc_req_if.sink                 req_chan,
   output logic                     q_valid,
   output tspc_pkg::item_type       q_item,
   input  logic                     q_pop,
   output tspc_pkg::front_stat_type stat
);

   logic [tspc_pkg::CNT_W-1:0]  arr_count_ff, arr_count_in;
   logic [tspc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tspc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tspc_pkg::QCNT_W-1:0] level_ff, level_in;
   tspc_pkg::item_type          q_mem_ff [tspc_pkg::QUEUE_DEPTH];
   tspc_pkg::item_type          push_item;
   logic                        push;
   logic                        store_full;

   assign req_chan.ready = (level_ff != tspc_pkg::QCNT_W'(tspc_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign store_full     = (arr_count_ff == tspc_pkg::CNT_W'(tspc_pkg::MAX_ELEMENTS));

   always_comb begin
      push_item.value = req_chan.element_value;
      push_item.last  = req_chan.last_element;
      push_item.drop  = store_full;
      push_item.slot  = arr_count_ff[tspc_pkg::IDX_W-1:0];
   end

   always_comb begin
      arr_count_in = arr_count_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      level_in     = level_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
         // restart slot numbering after the last word of an array
         if (req_chan.last_element) begin
            arr_count_in = '0;
         end else if (!store_full) begin
            arr_count_in = arr_count_ff + 1'b1;
         end
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push && q_pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arr_count_ff <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         level_ff     <= '0;
      end else begin
         arr_count_ff <= arr_count_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_valid        = (level_ff != '0);
   assign q_item         = q_mem_ff[rd_ptr_ff];
   assign stat.arr_count = arr_count_ff;
   assign stat.q_level   = level_ff;

endmodule

// ===== hdl/tspc_back.sv =====
// Back end: scan the stored elements for each queued word, count matches, emit results.
module tspc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [tspc_pkg::ELEM_W-1:0] target_sum,
   input  logic                               q_valid,
   input  tspc_pkg::item_type                 q_item,
   output logic                               q_pop,
   tspc_rsp_if.source                         rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_EMIT  = 4'b1000
   } back_state_type;

   back_state_type               state_ff, state_in;
   logic [tspc_pkg::ELEM_W-1:0]  value_ff, value_in;
   logic                         last_ff, last_in;
   logic [tspc_pkg::IDX_W-1:0]   slot_ff, slot_in;
   logic [tspc_pkg::IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [tspc_pkg::PAIR_W-1:0]  pairs_ff, pairs_in;
   logic                         dropped_ff, dropped_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tspc_pkg::PAIR_W-1:0]  rsp_pairs_ff, rsp_pairs_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;
   logic [tspc_pkg::ELEM_W-1:0]  rd_data;
   logic [tspc_pkg::ELEM_W:0]    pair_sum;
   logic                         match;
   logic                         ram_wr;
   logic                         ram_rd;
   logic                         out_free;

   tspc_ram #(
      .WIDTH(tspc_pkg::ELEM_W),
      .DEPTH(tspc_pkg::MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (slot_ff),
      .wr_data (value_ff),
      .rd_en   (ram_rd),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // 33 bit sum never wraps
   assign pair_sum = {value_ff[tspc_pkg::ELEM_W-1], value_ff}
                   + {rd_data[tspc_pkg::ELEM_W-1], rd_data};
   assign match    = (pair_sum == {target_sum[tspc_pkg::ELEM_W-1], target_sum});
   assign ram_rd   = (state_ff == ST_SCAN);
   assign ram_wr   = (state_ff == ST_WRITE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = 1'b0;
      pairs_in     = pairs_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pairs_in = rsp_pairs_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // data read in the previous cycle is compared now
      if (rd_pend_ff && match && (pairs_ff != tspc_pkg::PAIR_LIMIT)) begin
         pairs_in = pairs_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               value_in  = q_item.value;
               last_in   = q_item.last;
               slot_in   = q_item.slot;
               rd_idx_in = '0;
               if (q_item.drop) begin
                  dropped_in = 1'b1;
                  state_in   = q_item.last ? ST_EMIT : ST_IDLE;
               end else if (q_item.slot == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            rd_idx_in  = rd_idx_ff + 1'b1;
            if (rd_idx_ff == tspc_pkg::IDX_W'(slot_ff - 1'b1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pairs_in = pairs_ff;
               rsp_ovf_in   = dropped_ff;
               pairs_in     = '0;
               dropped_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         pairs_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         pairs_ff     <= pairs_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      slot_ff      <= slot_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_pairs_ff <= rsp_pairs_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.pair_count        = rsp_pairs_ff;
   assign rsp_chan.capacity_overflow = rsp_ovf_ff;

endmodule

// ===== hdl/target_sum_pair_counter.sv =====
// Top level of the target sum pair counter: front end, queue, scan engine, target register.
//
// Usage:
//   req_chan carries one array element per word (element_value, last_element).
//   rsp_chan returns one word per array, after the word marked last:
//   pair_count (unordered pairs whose 33 bit sum equals target_sum) and
//   capacity_overflow (elements beyond the store depth were dropped).
//   csr_chan writes target_sum; it is always ready. The user must write it only
//   while the block is idle; the block itself does not enforce this.
// Timing:
//   The front end takes a word whenever its 4-word queue has room, so short
//   bursts go in back to back. The scan engine reads the element store one
//   entry per cycle through its single read port: a kept element goes through
//   the idle step, one scan read per element ahead of it in the array and a
//   store write; a dropped one only the idle step; a last word then passes the
//   emit step, which loads the result register that drives the response.
// Reset:
//   Clears the queue, counts, flags, result valid bit and target_sum to 0.
//   The store itself is not cleared; only entries of the current array are read.
// Stall:
//   A result waits in the output register until taken; the engine holds in
//   its emit step only if a second result is ready before the first is taken.
module target_sum_pair_counter (
   input  logic       clock,
   input  logic       reset,
   tspc_req_if.sink   req_chan,
   tspc_rsp_if.source rsp_chan,
   tspc_csr_if.sink   csr_chan
);

   logic signed [tspc_pkg::ELEM_W-1:0] target_ff;
   logic                               q_valid;
   logic                               q_pop;
   tspc_pkg::item_type                 q_item;
   tspc_pkg::front_stat_type           front_stat;

   // target register: take every write at once
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_chan.valid) begin
         target_ff <= csr_chan.target_sum;
      end
   end

   // accept, classify against store depth, queue
   tspc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .stat     (front_stat)
   );

   // scan stored elements, count matches, hold the result word
   tspc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .target_sum (target_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_chan   (rsp_chan)
   );

   // the engine never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // slot count never runs past the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      front_stat.arr_count <= tspc_pkg::CNT_W'(tspc_pkg::MAX_ELEMENTS))
      else $error("array count beyond store depth");

   // queue level goes up by one on a push without a pop
   a_level_track: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !q_pop)
      |=> front_stat.q_level == $past(front_stat.q_level) + 1'b1)
      else $error("queue level did not advance on push");

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result word valid after reset");

endmodule

// ===== sim/tspc_pair_checker.sv =====
// Checker for the target sum pair counter: predicts pair count words and compares them.
`timescale 1ns / 100ps

module tspc_pair_checker (
   input  logic clock,
   input  logic reset,
   tspc_req_if  req_chan,
   tspc_rsp_if  rsp_chan,
   tspc_csr_if  csr_chan,
   output int   error_count,
   output int   counts_owed
);

   typedef struct packed {
      logic [tspc_pkg::PAIR_W-1:0] pair_count;
      logic                        capacity_overflow;
   } pair_count_word_type;

   logic signed [tspc_pkg::ELEM_W-1:0] kept_values [tspc_pkg::MAX_ELEMENTS];
   int unsigned                        kept_total;
   logic [tspc_pkg::PAIR_W-1:0]        pairs_so_far;
   logic                               dropped_any;
   logic signed [tspc_pkg::ELEM_W-1:0] target_value;
   pair_count_word_type                owed_counts [$];
   int                                 errors;

   // add one element to the current array; queue the count word on the last one
   function automatic void absorb_element(logic signed [tspc_pkg::ELEM_W-1:0] value,
                                          logic last);
      pair_count_word_type word;
      if (kept_total < tspc_pkg::MAX_ELEMENTS) begin
         for (int i = 0; i < kept_total; i++) begin
            // sum taken in 64 bits, no wrap
            if (longint'(value) + longint'(kept_values[i]) == longint'(target_value) &&
                pairs_so_far != tspc_pkg::PAIR_LIMIT)
               pairs_so_far++;
         end
         kept_values[kept_total] = value;
         kept_total++;
      end else begin
         dropped_any = 1'b1;
      end
      if (last) begin
         word.pair_count        = pairs_so_far;
         word.capacity_overflow = dropped_any;
         owed_counts.insert(owed_counts.size(), word);
         kept_total   = 0;
         pairs_so_far = '0;
         dropped_any  = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : watch
      pair_count_word_type got;
      pair_count_word_type want;
      if (reset) begin
         kept_total   = 0;
         pairs_so_far = '0;
         dropped_any  = 1'b0;
         target_value = '0;
         errors       = 0;
         owed_counts.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.pair_count        = rsp_chan.pair_count;
            got.capacity_overflow = rsp_chan.capacity_overflow;
            if (owed_counts.size() == 0) begin
               errors++;
               $error("unexpected word: pair_count %0d, capacity_overflow %0b",
                      got.pair_count, got.capacity_overflow);
            end else begin
               want = owed_counts.pop_front();
               if (got.pair_count !== want.pair_count) begin
                  errors++;
                  $error("pair_count: expected %0d, actual %0d",
                         want.pair_count, got.pair_count);
               end
               if (got.capacity_overflow !== want.capacity_overflow) begin
                  errors++;
                  $error("capacity_overflow: expected %0b, actual %0b",
                         want.capacity_overflow, got.capacity_overflow);
               end
            end
         end
         if (csr_chan.valid && csr_chan.ready)
            target_value = csr_chan.target_sum;
         if (req_chan.valid && req_chan.ready)
            absorb_element(req_chan.element_value, req_chan.last_element);
      end
      counts_owed <= owed_counts.size();
      error_count <= errors;
   end

endmodule

// ===== sim/target_sum_pair_counter_test.sv =====
// Testbench top for the target sum pair counter: stimulus, receiver, watchdog and verdict.
`timescale 1ns / 100ps

module target_sum_pair_counter_test;

   localparam logic signed [tspc_pkg::ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
   localparam logic signed [tspc_pkg::ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;

   localparam int IDLE_PCT      = 33;     // idle cycles per hundred on each side
   localparam int HOLD_AT       = 100;    // start the long receiver hold-off at this word
   localparam int HOLD_CYCLES   = 600;
   localparam int CALM_FROM     = 400;    // words in this window see no idling at all
   localparam int CALM_TO       = 700;
   localparam int PHASE_WORDS   = 166;    // small-array words per random phase
   localparam int SETTLE_CYCLES = 300;    // longer than the slowest element scan
   localparam int QUIET_LIMIT   = 20000;  // cycles with no handshake before giving up

   logic clock = 1'b0;
   logic reset;

   tspc_req_if req_chan ();
   tspc_rsp_if rsp_chan ();
   tspc_csr_if csr_chan ();

   int error_count;
   int counts_owed;
   int words_taken;
   int quiet_cycles;

   // current target and the elements sent so far in the open array
   logic signed [tspc_pkg::ELEM_W-1:0] target_now;
   logic signed [tspc_pkg::ELEM_W-1:0] open_array [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   target_sum_pair_counter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   tspc_pair_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_chan    (csr_chan),
      .error_count (error_count),
      .counts_owed (counts_owed)
   );

   // count accepted element words; the idling window and hold-off key off this
   always @(posedge clock) begin
      if (reset)
         words_taken <= 0;
      else if (req_chan.valid && req_chan.ready)
         words_taken <= words_taken + 1;
   end

   // watchdog: end the run when no channel has moved a word for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("target_sum_pair_counter_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic bit in_calm_window();
      return words_taken >= CALM_FROM && words_taken < CALM_TO;
   endfunction

   // Choose an element that is likely to pair up: the complement of an element
   // already sent, a value near half the target, an extreme or a value near zero, or anything at all.
   function automatic logic signed [tspc_pkg::ELEM_W-1:0] pick_element();
      int unsigned roll;
      longint      partner_need;
      roll = $urandom_range(99);
      if (roll < 35 && open_array.size() > 0) begin
         partner_need = longint'(target_now) -
                        longint'(open_array[$urandom_range(open_array.size() - 1)]);
         if (partner_need >= longint'(ELEM_MIN) && partner_need <= longint'(ELEM_MAX))
            return partner_need[tspc_pkg::ELEM_W-1:0];
      end
      if (roll < 55)
         return (target_now >>> 1) + 32'($urandom_range(2)) - 32'd1;
      if (roll < 70) begin
         case ($urandom_range(4))
            0: return ELEM_MIN;
            1: return ELEM_MAX;
            2: return '0;
            3: return '1;
            default: return 32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // Offer one element word and hold it until the block takes it. Valid stays
   // high into the next word unless a random gap drops it.
   task automatic send_word(input logic signed [tspc_pkg::ELEM_W-1:0] value, input logic last);
      while (!in_calm_window() && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.element_value <= value;
      req_chan.last_element  <= last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      open_array.insert(open_array.size(), value);
   endtask

   // Stream one whole array; the zero-heavy form piles up pairs for target 0.
   task automatic send_array(input int unsigned length, input bit zero_heavy);
      logic signed [tspc_pkg::ELEM_W-1:0] value;
      open_array.delete();
      for (int unsigned i = 0; i < length; i++) begin
         if (zero_heavy)
            value = ($urandom_range(4) < 3) ? 32'sd0 : (($urandom_range(1) == 0) ? 32'sd1 : '1);
         else
            value = pick_element();
         send_word(value, i == length - 1);
      end
   endtask

   // Write the target; only called while the block is idle.
   task automatic write_target(input logic signed [tspc_pkg::ELEM_W-1:0] value);
      csr_chan.valid      <= 1'b1;
      csr_chan.target_sum <= value;
      @(posedge clock);
      while (!csr_chan.ready)
         @(posedge clock);
      csr_chan.valid <= 1'b0;
      target_now = value;
   endtask

   // Drop valid, wait for every owed count word, then let the scan engine drain.
   task automatic end_phase();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (counts_owed != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: random ready, one long hold-off so the block backs up and
   // stalls its input, and a calm stretch with ready held high.
   initial begin : receiver
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && words_taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= in_calm_window() || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin : stimulus
      int unsigned                        phase_words;
      int unsigned                        length;
      logic signed [tspc_pkg::ELEM_W-1:0] goal;

      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.element_value <= '0;
      req_chan.last_element  <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.target_sum    <= '0;
      target_now = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, target left at its reset value of 0.
      // Three equal elements: every unordered pair counts once.
      send_word(32'sd0, 1'b0);
      send_word(32'sd0, 1'b0);
      send_word(32'sd0, 1'b1);
      // Two minimums sum to -2^32, which a 32 bit sum would wrap to 0.
      send_word(ELEM_MIN, 1'b0);
      send_word(ELEM_MIN, 1'b0);
      send_word(32'sd5, 1'b0);
      send_word(-32'sd5, 1'b0);
      send_word(ELEM_MAX, 1'b0);
      send_word(32'sh8000_0001, 1'b1);
      // Single-element array: no pair at all.
      send_word(32'sd1234, 1'b1);
      end_phase();

      // Two maximums sum to 2^32 - 2, which a 32 bit sum would wrap to -2.
      write_target(-32'sd2);
      send_word(ELEM_MAX, 1'b0);
      send_word(ELEM_MAX, 1'b0);
      send_word('1, 1'b0);
      send_word('1, 1'b1);
      end_phase();

      // Most negative target.
      write_target(ELEM_MIN);
      send_word(ELEM_MIN, 1'b0);
      send_word(32'sd0, 1'b0);
      send_word(32'shC000_0000, 1'b0);
      send_word(32'shC000_0000, 1'b1);
      end_phase();

      // Most positive target.
      write_target(ELEM_MAX);
      send_word(ELEM_MAX, 1'b0);
      send_word(32'sd0, 1'b0);
      send_word(32'sd1, 1'b0);
      send_word(32'sh7FFF_FFFE, 1'b1);
      end_phase();

      // Random phases, each under its own target. Most arrays are short; one
      // phase adds a full store of near-zero elements and another an array
      // that runs past capacity, so its tail and its last word are dropped.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       goal = $urandom;
            1:       goal = int'($urandom_range(20)) - 10;
            2:       goal = '0;
            3:       goal = ELEM_MIN;
            4:       goal = ELEM_MAX;
            5:       goal = '1;
            default: goal = $urandom;
         endcase
         write_target(goal);
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            length = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_array(length, 1'b0);
            phase_words += length;
         end
         if (phase == 2)
            send_array(tspc_pkg::MAX_ELEMENTS, 1'b1);
         if (phase == 4)
            send_array(tspc_pkg::MAX_ELEMENTS + 4, 1'b0);
         end_phase();
      end

      if (error_count == 0 && counts_owed == 0) begin
         $display("target_sum_pair_counter_test: clean");
      end else begin
         $display("target_sum_pair_counter_test: errors");
      end
      $finish;
   end

endmodule
